// File: src/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;

  typedef logic [1:0] status_t;

  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_REMOVED  = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage
`default_nettype wire

// File: src/stable_min_priority_queue_core.sv
// Insert: S_WR, S_DONE if empty; else each entry compared passes S_RD, S_CMP in
// the single compare unit, shifted back if greater, then S_WR, S_DONE. Remove:
// S_RRD, S_RDAT, S_DONE; full insert, empty remove: S_DONE. One word at a time.
// A finished word waits in the output register while the next word is taken.
// Reset (rst, synchronous) empties the queue; the entry memory is not cleared.
`default_nettype none
module stable_min_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [PRIO_W-1:0] priority_req,
  input  wire logic [TAG_W-1:0]  tag,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [PRIO_W-1:0]      out_priority,
  output logic [TAG_W-1:0]       out_tag
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  spq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .priority_req (priority_req),
    .tag          (tag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  spq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// File: src/spq_store.sv
`default_nettype none
module spq_store import spq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/spq_ctrl.sv
`default_nettype none
module spq_ctrl import spq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int SW = AW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [PRIO_W-1:0] priority_req,
  input  wire logic [TAG_W-1:0]  tag,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output status_t                status,
  output logic [PRIO_W-1:0]      out_priority,
  output logic [TAG_W-1:0]       out_tag,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_addr,
  output entry_t                 mem_wdata,
  input  wire entry_t            mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_WR,
    S_RRD,
    S_RDAT,
    S_DONE
  } state_t;

  state_t        state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  entry_t        new_ent;
  status_t       res_status;
  entry_t        res_ent;
  entry_t        out_ent;
  status_t       out_status;

  logic [AW-1:0] off;
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;
  logic          gt;
  logic          full;
  logic          out_busy;

  always_comb begin
    case (state)
      S_RD:    off = idx - AW'(1);
      S_RRD:   off = '0;
      S_RDAT:  off = AW'(1);
      default: off = idx;
    endcase
  end

  assign sum      = {1'b0, head} + {1'b0, off};
  assign wrapped  = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
  assign mem_addr = wrapped[AW-1:0];

  assign gt        = mem_rdata.prio > new_ent.prio;
  assign mem_we    = ((state == S_CMP) && gt) || (state == S_WR);
  assign mem_wdata = (state == S_CMP) ? mem_rdata : new_ent;

  assign full     = (count == CW'(DEPTH));
  assign out_busy = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE);

  assign status       = out_status;
  assign out_priority = out_ent.prio;
  assign out_tag      = out_ent.tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            new_ent.prio <= priority_req;
            new_ent.tag  <= tag;
            res_ent      <= '0;
            if (req_type == REQ_INSERT) begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                idx   <= count[AW-1:0];
                state <= (count == '0) ? S_WR : S_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_RRD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (gt) begin
            idx   <= idx - AW'(1);
            state <= (idx == AW'(1)) ? S_WR : S_RD;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          count      <= count + CW'(1);
          res_status <= ST_INSERTED;
          state      <= S_DONE;
        end
        S_RRD: begin
          state <= S_RDAT;
        end
        S_RDAT: begin
          res_status <= ST_REMOVED;
          res_ent    <= mem_rdata;
          head       <= mem_addr;
          count      <= count - CW'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_busy) begin
            out_status <= res_status;
            out_ent    <= res_ent;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/queue_order_checker.sv
`timescale 1ns / 1ps
module queue_order_checker import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              req_type,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TAG_W-1:0]  tag,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        status,
  input  logic [PRIO_W-1:0] out_priority,
  input  logic [TAG_W-1:0]  out_tag,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    status_t           st;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } outcome_t;

  entry_t   held [DEPTH];
  int       held_count;
  outcome_t due_q [$];
  int       errors;

  initial begin
    held_count = 0;
    errors     = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic outcome_t serve_request(input logic rt, input logic [PRIO_W-1:0] p,
                                             input logic [TAG_W-1:0] t);
    outcome_t r;
    int       pos;
    int       i;
    r = '0;
    if (rt == REQ_INSERT) begin
      if (held_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held[pos].prio <= p) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].prio = p;
        held[pos].tag  = t;
        held_count++;
        r.st = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.st = ST_EMPTY;
    end else begin
      r.st   = ST_REMOVED;
      r.prio = held[0].prio;
      r.tag  = held[0].tag;
      for (i = 1; i < held_count; i++) held[i-1] = held[i];
      held_count--;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    fail_count = errors;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      held_count = 0;
      due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word: status %0d prio %0d tag %h",
                                  status, out_priority, out_tag));
        end else begin
          want = due_q.pop_front();
          if (want.st !== status || want.prio !== out_priority || want.tag !== out_tag)
            flag_mismatch($sformatf(
              "mismatch: expected status %0d prio %0d tag %h, got status %0d prio %0d tag %h",
              want.st, want.prio, want.tag, status, out_priority, out_tag));
        end
      end
      if (in_valid && in_ready)
        due_q.push_back(serve_request(req_type, priority_req, tag));
    end
    pending = due_q.size();
  end

endmodule

// File: test/tb_stable_min_priority_queue_core.sv
`timescale 1ns / 1ps
module tb_stable_min_priority_queue_core;
  import spq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RAND_WORDS  = 450;
  localparam int QUIET_TAIL  = 60;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              req_type;
  logic [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]  tag;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0]  out_tag;
  int                fail_count;
  int                pending;
  int                cycles;
  int                stall_left;
  bit                idle_on;

  stable_min_priority_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .priority_req(priority_req), .tag(tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_priority(out_priority), .out_tag(out_tag)
  );

  queue_order_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .priority_req(priority_req), .tag(tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_priority(out_priority), .out_tag(out_tag),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    stall_left = 0;
    out_ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic rt, input logic [PRIO_W-1:0] p,
                           input logic [TAG_W-1:0] t);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= rt;
    priority_req <= p;
    tag          <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  logic [PRIO_W-1:0] fill_prio [DEPTH] = '{8'd5, 8'd0, 8'd255, 8'd5, 8'd0, 8'd255, 8'd5,
                                           8'd128, 8'd0, 8'd255, 8'd1, 8'd254, 8'd5,
                                           8'd7, 8'd7, 8'd3};

  initial begin : stimulus
    int                n;
    int                k;
    int                seg_len;
    int                ins_pct;
    bit                narrow;
    logic              rt;
    logic [PRIO_W-1:0] p;
    logic [TAG_W-1:0]  t;

    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_INSERT;
    priority_req = '0;
    tag          = '0;
    idle_on      = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(REQ_REMOVE, 8'hFF, 16'hFFFF);
    for (k = 0; k < DEPTH; k++) begin
      t = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(k * 16'h1111 + 16'h0A00);
      send_word(REQ_INSERT, fill_prio[k], t);
    end
    send_word(REQ_INSERT, 8'd0, 16'hBEEF);
    for (k = 0; k < 5; k++) send_word(REQ_REMOVE, 8'($urandom), 16'($urandom));

    n = 0;
    while (n < RAND_WORDS) begin
      seg_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0: ins_pct = 15;
        1: ins_pct = 50;
        default: ins_pct = 85;
      endcase
      narrow  = 1'($urandom_range(0, 1));
      idle_on = (n < RAND_WORDS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < seg_len && n < RAND_WORDS; k++) begin
        if (n >= RAND_WORDS - QUIET_TAIL) idle_on = 1'b0;
        rt = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
        if (narrow) begin
          p = 8'($urandom_range(0, 3));
          if ($urandom_range(0, 1)) p = ~p;
        end else begin
          p = 8'($urandom_range(0, 255));
        end
        t = 16'($urandom);
        send_word(rt, p, t);
        n++;
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: stable_min_priority_queue_core.f
src/spq_pkg.sv
src/spq_store.sv
src/spq_ctrl.sv
src/stable_min_priority_queue_core.sv
test/queue_order_checker.sv
test/tb_stable_min_priority_queue_core.sv
